### rtl/u16u8_pkg.sv
// Shared types, constants and UTF-8 encode helpers for the UTF-16 to UTF-8 transcoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package u16u8_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;
    localparam logic [5:0]  HIGH_TAG   = 6'b110110;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    localparam logic [20:0] MAX_1B = 21'h00007F;
    localparam logic [20:0] MAX_2B = 21'h0007FF;
    localparam logic [20:0] MAX_3B = 21'h00FFFF;

    localparam logic [7:0] LEAD_2B = 8'hC0;
    localparam logic [7:0] LEAD_3B = 8'hE0;
    localparam logic [7:0] LEAD_4B = 8'hF0;
    localparam logic [7:0] CONT_B  = 8'h80;

    localparam logic [2:0] LEN_1 = 3'd1;
    localparam logic [2:0] LEN_2 = 3'd2;
    localparam logic [2:0] LEN_3 = 3'd3;
    localparam logic [2:0] LEN_4 = 3'd4;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_string;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
    } out_word_t;

    typedef struct packed {
        logic        flush_valid;
        logic [15:0] flush_cp;
        logic        main_valid;
        logic [20:0] main_cp;
        logic        eos;
    } job_t;

    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] len;
        if (cp <= MAX_1B) begin
            len = LEN_1;
        end else if (cp <= MAX_2B) begin
            len = LEN_2;
        end else if (cp <= MAX_3B) begin
            len = LEN_3;
        end else begin
            len = LEN_4;
        end
        return len;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                             input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (len)
            LEN_1: b = {1'b0, cp[6:0]};
            LEN_2: begin
                case (idx)
                    2'd0:    b = LEAD_2B | {3'b000, cp[10:6]};
                    default: b = CONT_B | {2'b00, cp[5:0]};
                endcase
            end
            LEN_3: begin
                case (idx)
                    2'd0:    b = LEAD_3B | {4'b0000, cp[15:12]};
                    2'd1:    b = CONT_B | {2'b00, cp[11:6]};
                    default: b = CONT_B | {2'b00, cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    b = LEAD_4B | {5'b00000, cp[20:18]};
                    2'd1:    b = CONT_B | {2'b00, cp[17:12]};
                    2'd2:    b = CONT_B | {2'b00, cp[11:6]};
                    default: b = CONT_B | {2'b00, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### rtl/u16u8_front.sv
// Front end: accepts UTF-16 words, tracks a held high surrogate, builds encode jobs.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire u16u8_pkg::in_word_t item,
    input  wire logic               q_full,
    output logic                    q_push,
    output u16u8_pkg::job_t         q_job
);

    logic       holding_reg;
    logic [9:0] held_bits_reg;
    logic       holding_next;
    logic [9:0] held_bits_next;
    logic       is_high;
    logic       is_low;
    logic       accept;

    assign accept = push && !q_full;

    always_comb
    begin
        is_high = item.code_unit inside {[u16u8_pkg::HIGH_FIRST:u16u8_pkg::HIGH_LAST]};
        is_low  = item.code_unit inside {[u16u8_pkg::LOW_FIRST:u16u8_pkg::LOW_LAST]};

        q_job.eos         = item.end_of_string;
        q_job.flush_valid = 1'b0;
        q_job.flush_cp    = {u16u8_pkg::HIGH_TAG, held_bits_reg};
        q_job.main_valid  = 1'b1;
        q_job.main_cp     = {5'b00000, item.code_unit};
        holding_next      = 1'b0;
        held_bits_next    = 10'd0;

        if (holding_reg && is_low) begin
            q_job.main_cp = u16u8_pkg::SUPP_BASE
                            + {1'b0, held_bits_reg, item.code_unit[9:0]};
        end else begin
            q_job.flush_valid = holding_reg;
            if (is_high && !item.end_of_string) begin
                q_job.main_valid = 1'b0;
                holding_next     = 1'b1;
                held_bits_next   = item.code_unit[9:0];
            end
        end

        q_push = accept && (q_job.flush_valid || q_job.main_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            holding_reg   <= 1'b0;
            held_bits_reg <= 10'd0;
        end else if (accept) begin
            holding_reg   <= holding_next;
            held_bits_reg <= held_bits_next;
        end
    end

endmodule

`default_nettype wire

### rtl/u16u8_queue.sv
// Short job queue between the front end and the byte serializer.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_queue #(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire u16u8_pkg::job_t wr_job,
    output logic                 full,
    input  wire logic            pop,
    output u16u8_pkg::job_t      rd_job,
    output logic                 empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u16u8_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_job  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/u16u8_back.sv
// Back end: takes encode jobs from the queue and emits UTF-8 bytes through an output register.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_empty,
    input  wire u16u8_pkg::job_t  q_job,
    output logic                  q_pop,
    output logic                  empty,
    input  wire logic             pop,
    output u16u8_pkg::out_word_t  result
);

    typedef enum logic [1:0] {IDLE, FLUSH, MAIN} state_t;

    state_t               state_reg;
    u16u8_pkg::job_t      job_reg;
    logic [1:0]           idx_reg;
    logic                 out_valid_reg;
    u16u8_pkg::out_word_t out_reg;

    logic [20:0] cur_cp;
    logic [2:0]  cur_len;
    logic [7:0]  cur_byte;
    logic        seg_end;
    logic        item_end;
    logic        slot_free;

    always_comb
    begin
        cur_cp    = (state_reg == FLUSH) ? {5'b00000, job_reg.flush_cp} : job_reg.main_cp;
        cur_len   = u16u8_pkg::utf8_len(cur_cp);
        cur_byte  = u16u8_pkg::utf8_byte(cur_cp, cur_len, idx_reg);
        seg_end   = ({1'b0, idx_reg} + 3'd1) == cur_len;
        item_end  = seg_end && ((state_reg == MAIN) || !job_reg.main_valid);
        slot_free = !out_valid_reg || pop;
        q_pop     = !q_empty && ((state_reg == IDLE) || (slot_free && item_end));
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= IDLE;
            job_reg       <= '0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end else begin
            if (slot_free) begin
                out_valid_reg       <= (state_reg != IDLE);
                out_reg.out_byte    <= cur_byte;
                out_reg.run_last    <= item_end;
                out_reg.string_done <= item_end && job_reg.eos;
            end
            if (q_pop) begin
                job_reg   <= q_job;
                idx_reg   <= 2'd0;
                state_reg <= q_job.flush_valid ? FLUSH : MAIN;
            end else if (state_reg != IDLE && slot_free) begin
                if (item_end) begin
                    state_reg <= IDLE;
                end else if (seg_end) begin
                    state_reg <= MAIN;
                    idx_reg   <= 2'd0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.string_done |-> out_reg.run_last)
        else $error("string_done without run_last");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != IDLE |-> ({1'b0, idx_reg} < cur_len))
        else $error("byte index beyond sequence length");

    a_flush_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == FLUSH |-> job_reg.flush_valid)
        else $error("flush phase without held surrogate");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(out_reg))
        else $error("output word changed while stalled");

endmodule

`default_nettype wire

### rtl/utf16_to_utf8_transcoder.sv
// Top level of the UTF-16 to UTF-8 transcoder: front end, job queue and byte serializer.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
//
// Input channel: drive item (code_unit, end_of_string) and raise push; a word is taken
// at a rising edge with push high and full low.
// Output channel: while empty is low, result holds the oldest UTF-8 byte with run_last
// marking the last byte an input word caused and string_done the last byte of the string.
// Raise pop to take it.
// A high surrogate that is not last yields no bytes until the next word arrives.
// A word's first byte passes through the job queue, the job register and the output register.
// Throughput: one byte per cycle while the receiver keeps popping; a BMP word yields 1 to 3
// bytes, a surrogate pair 4, and an unpaired held surrogate plus its successor up to 6.
// The job queue (QUEUE_DEPTH entries) lets the front end keep taking words while the
// serializer works; full rises only when the queue is full.
// When the receiver stalls, the byte on result holds and the serializer waits; the queue
// then fills and full rises.
// Reset clears the held surrogate, empties the queue and drops any pending bytes.
`default_nettype none

module utf16_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire u16u8_pkg::in_word_t item,
    output logic                     empty,
    input  wire logic                pop,
    output u16u8_pkg::out_word_t     result
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    u16u8_pkg::job_t wr_job;
    u16u8_pkg::job_t rd_job;

    assign full = q_full;

    u16u8_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (wr_job)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_job (wr_job),
        .full   (q_full),
        .pop    (q_pop),
        .rd_job (rd_job),
        .empty  (q_empty)
    );

    u16u8_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_job   (rd_job),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire
